/* sv/cle_pkg.sv */
// Shared types and character codes for the console line editor.
`timescale 1ns / 1ps

package cle_pkg;

   localparam int BUF_DEPTH_DEF = 128;

   // Request kinds
   localparam logic CMD_RECEIVE = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   // Escape phases
   localparam logic [1:0] PH_NORMAL  = 2'd0;
   localparam logic [1:0] PH_ESC     = 2'd1;
   localparam logic [1:0] PH_BRACKET = 2'd2;

   // Character codes
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_CTRL_C  = 8'h03;
   localparam logic [7:0] CH_CTRL_D  = 8'h04;
   localparam logic [7:0] CH_CTRL_H  = 8'h08;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_CTRL_P  = 8'h10;
   localparam logic [7:0] CH_CTRL_U  = 8'h15;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_LETTER_A = 8'h41;
   localparam logic [7:0] CH_LETTER_B = 8'h42;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] ERASE_MAX  = 8'hFF;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // take the request beat
      logic arrow_1;    // store the bracket of an arrow sequence
      logic arrow_2;    // store the letter and commit
      logic read_done;  // store data is back, finish the pop
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic read_start;   // read of a non-empty buffer
      logic arrow_start;  // arrow key with room for three bytes
   } dp_sts_type;

endpackage

/* sv/cle_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/cle_ctrl.sv */
// Sequencer for the console line editor: accept, multi-beat stores and reads, result strobe.
`timescale 1ns / 1ps

module cle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cle_pkg::dp_sts_type sts,
   output cle_pkg::dp_cmd_type cmd,
   output logic                busy,
   output logic                rsp_valid
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDW  = 3'd1;
   localparam logic [2:0] S_AR1  = 3'd2;
   localparam logic [2:0] S_AR2  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (sts.read_start) begin
                  state_in = S_RDW;
               end else if (sts.arrow_start) begin
                  state_in = S_AR1;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_RDW: begin
            cmd.read_done = 1'b1;
            state_in      = S_RESP;
         end
         S_AR1: begin
            cmd.arrow_1 = 1'b1;
            state_in    = S_AR2;
         end
         S_AR2: begin
            cmd.arrow_2 = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

/* sv/cle_datapath.sv */
// Pointers, escape phase, line store access and result registers.
`timescale 1ns / 1ps

module cle_datapath #(
   parameter int BUF_DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cle_pkg::dp_cmd_type cmd,
   output cle_pkg::dp_sts_type sts,
   input  logic                req_cmd,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_first_in_read,
   output logic                rsp_echo_valid,
   output logic [7:0]          rsp_echo_byte,
   output logic [7:0]          rsp_erase_count,
   output logic                rsp_line_ready,
   output logic                rsp_dump_request,
   output logic                rsp_interrupt_request,
   output logic                rsp_read_valid,
   output logic [7:0]          rsp_read_byte,
   output logic                rsp_read_end_of_line,
   output logic                rsp_read_eof,
   output logic                rsp_read_empty
);

   localparam int PW = $clog2(2 * BUF_DEPTH);
   localparam int AW = $clog2(BUF_DEPTH);
   localparam int EW = (PW + 1 > 8) ? PW + 1 : 8;
   localparam logic [PW:0]   DEPTH_W = (PW + 1)'(BUF_DEPTH);
   localparam logic [PW:0]   MOD_W   = (PW + 1)'(2 * BUF_DEPTH);
   localparam logic [PW-1:0] LAST_P  = PW'(2 * BUF_DEPTH - 1);

   function automatic logic [AW-1:0] to_addr(input logic [PW-1:0] p);
      logic [PW:0] pe;
      pe = {1'b0, p};
      return (pe >= DEPTH_W) ? AW'(pe - DEPTH_W) : AW'(pe);
   endfunction

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == LAST_P) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      return (p == '0) ? LAST_P : p - 1'b1;
   endfunction

   function automatic logic [PW:0] ptr_diff(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] ae;
      logic [PW:0] be;
      ae = {1'b0, a};
      be = {1'b0, b};
      return (ae >= be) ? ae - be : ae + MOD_W - be;
   endfunction

   function automatic logic [7:0] erase_sat(input logic [PW:0] d);
      logic [EW-1:0] dx;
      dx = EW'(d);
      return (dx > EW'(cle_pkg::ERASE_MAX)) ? cle_pkg::ERASE_MAX : dx[7:0];
   endfunction

   logic [PW-1:0] read_ptr_ff,   read_ptr_in;
   logic [PW-1:0] commit_ptr_ff, commit_ptr_in;
   logic [PW-1:0] edit_ptr_ff,   edit_ptr_in;
   logic [1:0]    phase_ff,      phase_in;
   logic [7:0]    letter_ff,     letter_in;
   logic          first_ff,      first_in;

   logic          echo_valid_ff, echo_valid_in;
   logic [7:0]    echo_byte_ff,  echo_byte_in;
   logic [7:0]    erase_ff,      erase_in;
   logic          ready_ff,      ready_in;
   logic          dump_ff,       dump_in;
   logic          intr_ff,       intr_in;
   logic          rd_valid_ff,   rd_valid_in;
   logic [7:0]    rd_byte_ff,    rd_byte_in;
   logic          rd_eol_ff,     rd_eol_in;
   logic          rd_eof_ff,     rd_eof_in;
   logic          rd_empty_ff,   rd_empty_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [7:0]    rd_data;

   logic [PW:0]   fill;
   logic [PW:0]   fill_committed;
   logic [PW:0]   uncommitted;
   logic          is_arrow;
   logic          arrow_room;
   logic          has_room;
   logic [7:0]    ch;

   assign fill           = ptr_diff(edit_ptr_ff, read_ptr_ff);
   assign fill_committed = ptr_diff(commit_ptr_ff, read_ptr_ff);
   assign uncommitted    = ptr_diff(edit_ptr_ff, commit_ptr_ff);
   assign has_room       = (fill < DEPTH_W);
   assign arrow_room     = (fill_committed + (PW + 1)'(3) <= DEPTH_W);
   assign is_arrow       = (req_rx_byte == cle_pkg::CH_LETTER_A)
                           || (req_rx_byte == cle_pkg::CH_LETTER_B);
   assign ch             = (req_rx_byte == cle_pkg::CH_CR) ? cle_pkg::CH_LF : req_rx_byte;

   assign sts.read_start  = (req_cmd == cle_pkg::CMD_READ) && (read_ptr_ff != commit_ptr_ff);
   assign sts.arrow_start = (req_cmd == cle_pkg::CMD_RECEIVE) && (phase_ff == cle_pkg::PH_BRACKET)
                            && is_arrow && arrow_room;

   always_comb begin
      read_ptr_in   = read_ptr_ff;
      commit_ptr_in = commit_ptr_ff;
      edit_ptr_in   = edit_ptr_ff;
      phase_in      = phase_ff;
      letter_in     = letter_ff;
      first_in      = first_ff;
      echo_valid_in = echo_valid_ff;
      echo_byte_in  = echo_byte_ff;
      erase_in      = erase_ff;
      ready_in      = ready_ff;
      dump_in       = dump_ff;
      intr_in       = intr_ff;
      rd_valid_in   = rd_valid_ff;
      rd_byte_in    = rd_byte_ff;
      rd_eol_in     = rd_eol_ff;
      rd_eof_in     = rd_eof_ff;
      rd_empty_in   = rd_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = to_addr(edit_ptr_ff);
      wr_data       = ch;

      if (cmd.accept) begin
         letter_in     = req_rx_byte;
         first_in      = req_first_in_read;
         echo_valid_in = 1'b0;
         echo_byte_in  = '0;
         erase_in      = '0;
         ready_in      = 1'b0;
         dump_in       = 1'b0;
         intr_in       = 1'b0;
         rd_valid_in   = 1'b0;
         rd_byte_in    = '0;
         rd_eol_in     = 1'b0;
         rd_eof_in     = 1'b0;
         rd_empty_in   = 1'b0;
         if (req_cmd == cle_pkg::CMD_READ) begin
            rd_empty_in = (read_ptr_ff == commit_ptr_ff);
         end else if (phase_ff == cle_pkg::PH_ESC) begin
            phase_in = (req_rx_byte == cle_pkg::CH_BRACKET) ? cle_pkg::PH_BRACKET
                                                            : cle_pkg::PH_NORMAL;
         end else if (phase_ff == cle_pkg::PH_BRACKET) begin
            phase_in = cle_pkg::PH_NORMAL;
            if (is_arrow) begin
               erase_in    = erase_sat(uncommitted);
               edit_ptr_in = commit_ptr_ff;
               if (arrow_room) begin
                  wr_en       = 1'b1;
                  wr_addr     = to_addr(commit_ptr_ff);
                  wr_data     = cle_pkg::CH_ESC;
                  edit_ptr_in = ptr_inc(commit_ptr_ff);
               end
            end
         end else if (req_rx_byte == cle_pkg::CH_ESC) begin
            phase_in = cle_pkg::PH_ESC;
         end else if (req_rx_byte == cle_pkg::CH_CTRL_C) begin
            intr_in = 1'b1;
         end else if (req_rx_byte == cle_pkg::CH_CTRL_P) begin
            dump_in = 1'b1;
         end else if (req_rx_byte == cle_pkg::CH_CTRL_U) begin
            erase_in    = erase_sat(uncommitted);
            edit_ptr_in = commit_ptr_ff;
         end else if ((req_rx_byte == cle_pkg::CH_CTRL_H)
                      || (req_rx_byte == cle_pkg::CH_DEL)) begin
            if (edit_ptr_ff != commit_ptr_ff) begin
               edit_ptr_in = ptr_dec(edit_ptr_ff);
               erase_in    = 8'd1;
            end
         end else if (req_rx_byte == cle_pkg::CH_TAB) begin
            if (has_room) begin
               wr_en         = 1'b1;
               edit_ptr_in   = ptr_inc(edit_ptr_ff);
               commit_ptr_in = ptr_inc(edit_ptr_ff);
               ready_in      = 1'b1;
            end
         end else if ((req_rx_byte != cle_pkg::CH_NUL) && has_room) begin
            echo_valid_in = 1'b1;
            echo_byte_in  = ch;
            wr_en         = 1'b1;
            edit_ptr_in   = ptr_inc(edit_ptr_ff);
            if ((ch == cle_pkg::CH_LF) || (ch == cle_pkg::CH_CTRL_D)
                || (fill + 1'b1 == DEPTH_W)) begin
               commit_ptr_in = ptr_inc(edit_ptr_ff);
               ready_in      = 1'b1;
            end
         end
      end

      if (cmd.arrow_1) begin
         wr_en       = 1'b1;
         wr_data     = cle_pkg::CH_BRACKET;
         edit_ptr_in = ptr_inc(edit_ptr_ff);
      end

      if (cmd.arrow_2) begin
         wr_en         = 1'b1;
         wr_data       = letter_ff;
         edit_ptr_in   = ptr_inc(edit_ptr_ff);
         commit_ptr_in = ptr_inc(edit_ptr_ff);
         ready_in      = 1'b1;
      end

      if (cmd.read_done) begin
         if (rd_data == cle_pkg::CH_CTRL_D) begin
            rd_eof_in = 1'b1;
            if (first_ff) begin
               read_ptr_in = ptr_inc(read_ptr_ff);
            end
         end else begin
            rd_valid_in = 1'b1;
            rd_byte_in  = rd_data;
            rd_eol_in   = (rd_data == cle_pkg::CH_LF);
            read_ptr_in = ptr_inc(read_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ptr_ff   <= '0;
         commit_ptr_ff <= '0;
         edit_ptr_ff   <= '0;
         phase_ff      <= cle_pkg::PH_NORMAL;
      end else begin
         read_ptr_ff   <= read_ptr_in;
         commit_ptr_ff <= commit_ptr_in;
         edit_ptr_ff   <= edit_ptr_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff     <= letter_in;
      first_ff      <= first_in;
      echo_valid_ff <= echo_valid_in;
      echo_byte_ff  <= echo_byte_in;
      erase_ff      <= erase_in;
      ready_ff      <= ready_in;
      dump_ff       <= dump_in;
      intr_ff       <= intr_in;
      rd_valid_ff   <= rd_valid_in;
      rd_byte_ff    <= rd_byte_in;
      rd_eol_ff     <= rd_eol_in;
      rd_eof_ff     <= rd_eof_in;
      rd_empty_ff   <= rd_empty_in;
   end

   cle_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (to_addr(read_ptr_ff)),
      .rd_data (rd_data)
   );

   assign rsp_echo_valid        = echo_valid_ff;
   assign rsp_echo_byte         = echo_byte_ff;
   assign rsp_erase_count       = erase_ff;
   assign rsp_line_ready        = ready_ff;
   assign rsp_dump_request      = dump_ff;
   assign rsp_interrupt_request = intr_ff;
   assign rsp_read_valid        = rd_valid_ff;
   assign rsp_read_byte         = rd_byte_ff;
   assign rsp_read_end_of_line  = rd_eol_ff;
   assign rsp_read_eof          = rd_eof_ff;
   assign rsp_read_empty        = rd_empty_ff;

endmodule

/* sv/console_line_editor.sv */
// Top level of the console line editor: controller, datapath and line store.
`timescale 1ns / 1ps

// Canonical terminal input editor. Each request beat (start high while busy
// is low) is either a typed byte (req_cmd = 0) or a read of one committed
// byte (req_cmd = 1), and produces exactly one result beat: rsp_valid is high
// for one clock and the result fields are valid only in that cycle. The
// receiver cannot stall, so capture the result whenever rsp_valid is high.
// Busy rises the cycle after a request beat and drops in the cycle after the
// result beat, so start may be held high for back-to-back requests.
// Per beat: a typed byte goes from accept straight to the result state; a
// read of a non-empty buffer passes S_RDW for the registered read of the line
// store; an arrow key (ESC [ A or ESC [ B) with room passes S_AR1 and S_AR2,
// since its three bytes go through the single store write port one per cycle.
// Typed bytes go into a ring store of BUF_DEPTH entries; bytes between the
// commit and edit positions form the line still being edited and are not
// visible to reads until LF, Ctrl-D, tab, an arrow key or a full store commits
// them. No clearing pass follows reset: the block accepts a beat right away.

module console_line_editor #(
   parameter int BUF_DEPTH = cle_pkg::BUF_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_cmd,
   input  logic [7:0] req_rx_byte,
   input  logic       req_first_in_read,
   output logic       rsp_valid,
   output logic       rsp_echo_valid,
   output logic [7:0] rsp_echo_byte,
   output logic [7:0] rsp_erase_count,
   output logic       rsp_line_ready,
   output logic       rsp_dump_request,
   output logic       rsp_interrupt_request,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_read_end_of_line,
   output logic       rsp_read_eof,
   output logic       rsp_read_empty
);

   cle_pkg::dp_cmd_type dp_cmd;
   cle_pkg::dp_sts_type dp_sts;

   // Sequence the beat: accept, extra store or read cycles, then strobe the result.
   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (dp_sts),
      .cmd       (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Hold the indices, escape phase and line store; build the result fields.
   cle_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (dp_cmd),
      .sts                   (dp_sts),
      .req_cmd               (req_cmd),
      .req_rx_byte           (req_rx_byte),
      .req_first_in_read     (req_first_in_read),
      .rsp_echo_valid        (rsp_echo_valid),
      .rsp_echo_byte         (rsp_echo_byte),
      .rsp_erase_count       (rsp_erase_count),
      .rsp_line_ready        (rsp_line_ready),
      .rsp_dump_request      (rsp_dump_request),
      .rsp_interrupt_request (rsp_interrupt_request),
      .rsp_read_valid        (rsp_read_valid),
      .rsp_read_byte         (rsp_read_byte),
      .rsp_read_end_of_line  (rsp_read_end_of_line),
      .rsp_read_eof          (rsp_read_eof),
      .rsp_read_empty        (rsp_read_empty)
   );

endmodule
